### rtl/core/seismic_channel_block_decoder_defines.svh
// assertion macros shared by the channel block decoder modules
`ifndef SEISMIC_CHANNEL_BLOCK_DECODER_DEFINES_SVH
`define SEISMIC_CHANNEL_BLOCK_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising clk edge outside reset
`define SCBD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scbd assertion failed");

// next-cycle implication
`define SCBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scbd assertion failed");

`else

`define SCBD_ASSERT_IMPL(lbl, ante, cons)
`define SCBD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/core/scbd_pkg.sv
// shared types and constants of the channel block decoder
package scbd_pkg;

  localparam logic [11:0] MAX_RATE_RESET = 12'd1000;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_OVER_MAX   = 2'd1;
  localparam logic [1:0] ERR_BAD_SIZE   = 2'd2;
  localparam logic [1:0] ERR_ZERO_COUNT = 2'd3;

  typedef enum logic [1:0] {
    OP_HEADER,
    OP_ERROR,
    OP_SAMPLE
  } op_t;

  // one classified work unit handed from front to back
  typedef struct packed {
    op_t         op;
    logic [15:0] channel;
    logic [11:0] count;
    logic [14:0] bytes;
    logic [11:0] index;
    logic        first;
    logic [31:0] value;
    logic        pair;
    logic [3:0]  nib2;
    logic        last1;
    logic        last2;
    logic [1:0]  err;
  } entry_t;

endpackage

### rtl/core/seismic_channel_block_decoder.sv
// Channel block decoder: takes one stream byte per cycle while its internal
// queue has room and gives one result per cycle while out_stall is low. A
// nibble-coded difference byte yields two samples and so stays at the head of
// the queue until the result stage has given out both, which then limits the
// sustained rate for nibble blocks. A result reaches the output through the
// queue and the registered result stage after its last byte. max_rate is loaded
// through cfg_wr_en/cfg_wr_data and resets to 1000.

module seismic_channel_block_decoder #(
  parameter int unsigned QUEUE_DEPTH = scbd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [11:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [15:0]        channel,
  output logic [11:0]        sample_count,
  output logic [14:0]        block_bytes,
  output logic [11:0]        sample_index,
  output logic signed [31:0] sample_value,
  output logic [1:0]         error_code,
  output logic               last
);

  logic [11:0]      max_rate;
  logic             q_full, push, pop, q_valid;
  scbd_pkg::entry_t push_entry, q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rate <= scbd_pkg::MAX_RATE_RESET;
    end else if (cfg_wr_en) begin
      max_rate <= cfg_wr_data;
    end
  end

  scbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .max_rate   (max_rate),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  scbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  scbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .channel      (channel),
    .sample_count (sample_count),
    .block_bytes  (block_bytes),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .error_code   (error_code),
    .last         (last)
  );

endmodule

### rtl/core/scbd_front.sv
// front end: byte assembly, header checks and classification into queue entries
`include "seismic_channel_block_decoder_defines.svh"

module scbd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic [11:0]         max_rate,
  input  logic                q_full,
  output logic                push,
  output scbd_pkg::entry_t    push_entry
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_FIRST,
    PH_DIFF
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  byte_pos, byte_pos_next;
  logic [31:0] word, word_next;
  logic [15:0] channel, channel_next;
  logic [3:0]  size_code, size_code_next;
  logic [11:0] rate, rate_next;
  logic [11:0] pos, pos_next;
  logic [14:0] blk, blk_next;

  logic        accept;
  logic [31:0] word_shift;
  logic        fin1, fin2;
  logic [2:0]  bp_inc;
  logic [31:0] diff_ext;
  logic [11:0] hdr_rate;
  logic [3:0]  hdr_code;
  logic [11:0] hdr_rm1;
  logic [14:0] hdr_mul;
  logic [14:0] hdr_bytes;
  scbd_pkg::entry_t ent;

  assign accept     = in_valid && !q_full;
  assign in_stall   = q_full;
  assign word_shift = {word[23:0], data_byte};
  assign fin1       = ({1'b0, pos} + 13'd1) >= {1'b0, rate};
  assign fin2       = ({1'b0, pos} + 13'd2) >= {1'b0, rate};
  assign bp_inc     = {1'b0, byte_pos} + 3'd1;

  // sign extend the assembled difference by its byte count
  always_comb begin
    case (size_code)
      4'd1:    diff_ext = {{24{word_shift[7]}}, word_shift[7:0]};
      4'd2:    diff_ext = {{16{word_shift[15]}}, word_shift[15:0]};
      4'd3:    diff_ext = {{8{word_shift[23]}}, word_shift[23:0]};
      default: diff_ext = word_shift;
    endcase
  end

  // block size of the header being completed
  assign hdr_rate = word_shift[11:0];
  assign hdr_code = word_shift[15:12];
  assign hdr_rm1  = hdr_rate - 12'd1;

  always_comb begin
    case (hdr_code)
      4'd0:    hdr_mul = {4'b0, hdr_rate[11:1]};
      4'd1:    hdr_mul = {3'b0, hdr_rm1};
      4'd2:    hdr_mul = {2'b0, hdr_rm1, 1'b0};
      4'd3:    hdr_mul = {3'b0, hdr_rm1} + {2'b0, hdr_rm1, 1'b0};
      4'd4:    hdr_mul = {1'b0, hdr_rm1, 2'b0};
      default: hdr_mul = '0; // only used by a valid block with a count of one
    endcase
  end

  assign hdr_bytes = hdr_mul + 15'd8;

  always_comb begin
    phase_next     = phase;
    byte_pos_next  = byte_pos;
    word_next      = word;
    channel_next   = channel;
    size_code_next = size_code;
    rate_next      = rate;
    pos_next       = pos;
    blk_next       = blk;
    push           = 1'b0;

    ent         = '0;
    ent.op      = scbd_pkg::OP_SAMPLE;
    ent.channel = channel;
    ent.count   = rate;
    ent.bytes   = blk;
    ent.index   = pos;
    ent.err     = scbd_pkg::ERR_NONE;

    if (accept) begin
      if (phase == PH_DIFF && size_code == 4'd0) begin
        // nibble pair: high nibble first, low one dropped if the block ends
        push      = 1'b1;
        ent.value = {{28{data_byte[7]}}, data_byte[7:4]};
        ent.last1 = fin1;
        if (fin1) begin
          pos_next   = pos + 12'd1;
          phase_next = PH_HEADER;
        end else begin
          ent.pair  = 1'b1;
          ent.nib2  = data_byte[3:0];
          ent.last2 = fin2;
          pos_next  = pos + 12'd2;
          if (fin2) begin
            phase_next = PH_HEADER;
          end
        end
      end else begin
        word_next = word_shift;
        unique case (phase)
          PH_DIFF: begin
            if ({1'b0, bp_inc} < size_code) begin
              byte_pos_next = bp_inc[1:0];
            end else begin
              push          = 1'b1;
              ent.value     = diff_ext;
              ent.last1     = fin1;
              pos_next      = pos + 12'd1;
              byte_pos_next = '0;
              word_next     = '0;
              if (fin1) begin
                phase_next = PH_HEADER;
              end
            end
          end
          PH_HEADER: begin
            if (byte_pos != 2'd3) begin
              byte_pos_next = byte_pos + 2'd1;
            end else begin
              byte_pos_next  = '0;
              word_next      = '0;
              channel_next   = word_shift[31:16];
              size_code_next = hdr_code;
              rate_next      = hdr_rate;
              pos_next       = '0;
              blk_next       = hdr_bytes;
              push           = 1'b1;
              ent.channel    = word_shift[31:16];
              ent.count      = hdr_rate;
              ent.index      = '0;
              ent.bytes      = '0;
              ent.last1      = 1'b1;
              ent.op         = scbd_pkg::OP_ERROR;
              if (hdr_rate == 12'd0) begin
                ent.err = scbd_pkg::ERR_ZERO_COUNT;
              end else if (hdr_rate != 12'd1 && hdr_rate > max_rate) begin
                ent.err = scbd_pkg::ERR_OVER_MAX;
              end else if (hdr_rate != 12'd1 && hdr_code > 4'd4) begin
                ent.err = scbd_pkg::ERR_BAD_SIZE;
              end else begin
                ent.op     = scbd_pkg::OP_HEADER;
                ent.bytes  = hdr_bytes;
                ent.last1  = 1'b0;
                phase_next = PH_FIRST;
              end
            end
          end
          PH_FIRST: begin
            if (byte_pos != 2'd3) begin
              byte_pos_next = byte_pos + 2'd1;
            end else begin
              byte_pos_next = '0;
              word_next     = '0;
              push          = 1'b1;
              ent.first     = 1'b1;
              ent.value     = word_shift;
              ent.last1     = fin1;
              pos_next      = pos + 12'd1;
              phase_next    = fin1 ? PH_HEADER : PH_DIFF;
            end
          end
          default: begin
            phase_next = PH_HEADER;
          end
        endcase
      end
    end
  end

  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      byte_pos  <= '0;
      word      <= '0;
      channel   <= '0;
      size_code <= '0;
      rate      <= '0;
      pos       <= '0;
      blk       <= '0;
    end else begin
      phase     <= phase_next;
      byte_pos  <= byte_pos_next;
      word      <= word_next;
      channel   <= channel_next;
      size_code <= size_code_next;
      rate      <= rate_next;
      pos       <= pos_next;
      blk       <= blk_next;
    end
  end

  // multi-byte differences only run with a legal size code
  `SCBD_ASSERT_IMPL(a_diff_byte_pos, (phase == PH_DIFF && size_code != 4'd0),
                    (({2'b0, byte_pos} < size_code) && size_code <= 4'd4))

endmodule

### rtl/core/scbd_queue.sv
// small flop queue between the front and back ends
`include "seismic_channel_block_decoder_defines.svh"

module scbd_queue #(
  parameter int unsigned DEPTH = scbd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  scbd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output scbd_pkg::entry_t q_entry
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  scbd_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign full    = count == CW'(DEPTH);
  assign q_valid = count != '0;
  assign q_entry = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_SLOT) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_SLOT) ? '0 : rptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `SCBD_ASSERT_IMPL(a_no_overflow, push, !full)
  `SCBD_ASSERT_IMPL(a_no_underflow, pop, q_valid)

endmodule

### rtl/core/scbd_back.sv
// back end: sample accumulation and the registered result stage
`include "seismic_channel_block_decoder_defines.svh"

module scbd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  scbd_pkg::entry_t    q_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [15:0]         channel,
  output logic [11:0]         sample_count,
  output logic [14:0]         block_bytes,
  output logic [11:0]         sample_index,
  output logic signed [31:0]  sample_value,
  output logic [1:0]          error_code,
  output logic                last
);

  logic [31:0] acc;
  logic        half;
  logic        can_load, load;
  logic [31:0] sum1, sum2;

  assign can_load = !out_valid || !out_stall;
  assign load     = can_load && q_valid;
  // a nibble pair stays at the queue head until its second sample goes out
  assign pop      = load && (!q_entry.pair || half);

  assign sum1 = q_entry.first ? q_entry.value : acc + q_entry.value;
  assign sum2 = acc + {{28{q_entry.nib2[3]}}, q_entry.nib2};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
      acc       <= '0;
    end else begin
      if (can_load) begin
        out_valid <= q_valid;
      end
      if (load) begin
        channel      <= q_entry.channel;
        sample_count <= q_entry.count;
        block_bytes  <= q_entry.bytes;
        error_code   <= q_entry.err;
        unique case (q_entry.op)
          scbd_pkg::OP_SAMPLE: begin
            kind <= scbd_pkg::KIND_SAMPLE;
            if (!half) begin
              acc          <= sum1;
              sample_value <= sum1;
              sample_index <= q_entry.index;
              last         <= q_entry.last1;
              half         <= q_entry.pair;
            end else begin
              acc          <= sum2;
              sample_value <= sum2;
              sample_index <= q_entry.index + 12'd1;
              last         <= q_entry.last2;
              half         <= 1'b0;
            end
          end
          scbd_pkg::OP_HEADER: begin
            kind         <= scbd_pkg::KIND_HEADER;
            sample_value <= '0;
            sample_index <= '0;
            last         <= 1'b0;
          end
          scbd_pkg::OP_ERROR: begin
            kind         <= scbd_pkg::KIND_ERROR;
            sample_value <= '0;
            sample_index <= '0;
            last         <= 1'b1;
          end
          default: begin
            kind         <= scbd_pkg::KIND_ERROR;
            sample_value <= '0;
            sample_index <= '0;
            last         <= 1'b1;
          end
        endcase
      end
    end
  end

  // second half of a pair only while that pair heads the queue
  `SCBD_ASSERT_IMPL(a_half_on_pair, half,
                    q_valid && q_entry.pair && q_entry.op == scbd_pkg::OP_SAMPLE)

endmodule

### verif/testbench.sv
// testbench for the channel block decoder: byte-stream stimulus, result prediction and checks
`timescale 1ns / 1ps

typedef enum logic [1:0] {
  AT_HEADER,
  AT_FIRST,
  AT_DIFF
} stage_t;

typedef struct packed {
  logic [1:0]  kind;
  logic [15:0] channel;
  logic [11:0] count;
  logic [14:0] bytes;
  logic [11:0] index;
  logic [31:0] value;
  logic [1:0]  err;
  logic        last;
} decoded_t;

class block_tracker;
  stage_t      stage;
  logic [1:0]  byte_pos;
  logic [31:0] word;
  logic [15:0] chan;
  logic [3:0]  code;
  logic [11:0] count;
  logic [11:0] spos;
  logic [31:0] acc;
  logic [11:0] max_rate;
  decoded_t    due_outputs[$];
  int          failures;
  int          bytes_in;
  int          headers;
  int          samples;
  int          errors;

  function new();
    stage = AT_HEADER;
    byte_pos = '0;
    word = '0;
    chan = '0;
    code = '0;
    count = '0;
    spos = '0;
    acc = '0;
    max_rate = scbd_pkg::MAX_RATE_RESET;
    failures = 0;
    bytes_in = 0;
    headers = 0;
    samples = 0;
    errors = 0;
  endfunction

  function logic [14:0] block_len();
    int unsigned n;
    if (code == 4'd0) n = (int'(count) >> 1) + 8;
    else n = int'(code) * (int'(count) - 1) + 8;
    return n[14:0];
  endfunction

  function void add(logic [1:0] k, logic [14:0] nb, logic [11:0] idx, logic [31:0] v,
                    logic [1:0] e, logic l);
    decoded_t r;
    r.kind = k;
    r.channel = chan;
    r.count = count;
    r.bytes = nb;
    r.index = idx;
    r.value = v;
    r.err = e;
    r.last = l;
    due_outputs.push_back(r);
  endfunction

  function void emit_sample();
    logic fin;
    fin = (int'(spos) + 1 >= int'(count));
    add(scbd_pkg::KIND_SAMPLE, block_len(), spos, acc, scbd_pkg::ERR_NONE, fin);
    spos = spos + 12'd1;
    if (fin) stage = AT_HEADER;
  endfunction

  // called once per accepted item
  function void decode_byte(logic [7:0] b);
    logic [31:0] d;
    bytes_in++;
    if (stage == AT_DIFF && code == 4'd0) begin
      // high nibble first, the low one is dropped once the block is done
      acc = acc + {{28{b[7]}}, b[7:4]};
      emit_sample();
      if (stage == AT_DIFF) begin
        acc = acc + {{28{b[3]}}, b[3:0]};
        emit_sample();
      end
      return;
    end
    word = {word[23:0], b};
    if (stage == AT_DIFF) begin
      if (int'(byte_pos) + 1 < int'(code)) begin
        byte_pos++;
        return;
      end
      case (code)
        4'd1: d = {{24{word[7]}}, word[7:0]};
        4'd2: d = {{16{word[15]}}, word[15:0]};
        4'd3: d = {{8{word[23]}}, word[23:0]};
        default: d = word;
      endcase
      acc = acc + d;
      byte_pos = '0;
      word = '0;
      emit_sample();
      return;
    end
    if (byte_pos < 2'd3) begin
      byte_pos++;
      return;
    end
    byte_pos = '0;
    if (stage == AT_HEADER) begin
      chan = word[31:16];
      code = word[15:12];
      count = word[11:0];
      spos = '0;
      word = '0;
      // a count of one skips both the rate and the size check
      if (count == 12'd0) begin
        add(scbd_pkg::KIND_ERROR, '0, '0, '0, scbd_pkg::ERR_ZERO_COUNT, 1'b1);
      end else if (count != 12'd1 && count > max_rate) begin
        add(scbd_pkg::KIND_ERROR, '0, '0, '0, scbd_pkg::ERR_OVER_MAX, 1'b1);
      end else if (count != 12'd1 && code > 4'd4) begin
        add(scbd_pkg::KIND_ERROR, '0, '0, '0, scbd_pkg::ERR_BAD_SIZE, 1'b1);
      end else begin
        add(scbd_pkg::KIND_HEADER, block_len(), '0, '0, scbd_pkg::ERR_NONE, 1'b0);
        stage = AT_FIRST;
      end
      return;
    end
    acc = word;
    word = '0;
    stage = AT_DIFF;
    emit_sample();
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  function void compare_output(decoded_t got);
    decoded_t want;
    if (due_outputs.size() == 0) begin
      $error("unexpected result: kind %0d channel %0h index %0d", got.kind, got.channel,
             got.index);
      failures++;
      return;
    end
    want = due_outputs.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("channel", want.channel, got.channel);
    check_field("sample_count", want.count, got.count);
    check_field("block_bytes", want.bytes, got.bytes);
    check_field("sample_index", want.index, got.index);
    check_field("sample_value", want.value, got.value);
    check_field("error_code", want.err, got.err);
    check_field("last", want.last, got.last);
    if (want.kind == scbd_pkg::KIND_HEADER) headers++;
    else if (want.kind == scbd_pkg::KIND_SAMPLE) samples++;
    else errors++;
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_BYTES = 60;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [11:0]        cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         kind;
  logic [15:0]        channel;
  logic [11:0]        sample_count;
  logic [14:0]        block_bytes;
  logic [11:0]        sample_index;
  logic signed [31:0] sample_value;
  logic [1:0]         error_code;
  logic               last;

  block_tracker tracker;
  int           hold_left = 0;
  logic         sender_calm = 1'b0;
  int           mid_rate;

  seismic_channel_block_decoder dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .channel(channel),
    .sample_count(sample_count),
    .block_bytes(block_bytes),
    .sample_index(sample_index),
    .sample_value(sample_value),
    .error_code(error_code),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stall runs, calm stretches, and a long hold on request
  initial begin
    int run_left;
    int r;
    logic run_stall;
    decoded_t got;
    run_left = 0;
    run_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = {kind, channel, sample_count, block_bytes, sample_index, sample_value,
               error_code, last};
        tracker.compare_output(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            run_stall = 1'b0;
            run_left = $urandom_range(1, 8);
          end else if (r < 62) begin
            run_stall = 1'b0;
            run_left = $urandom_range(30, 120);
          end else if (r < 90) begin
            run_stall = 1'b1;
            run_left = $urandom_range(1, 3);
          end else if (r < 98) begin
            run_stall = 1'b1;
            run_left = $urandom_range(4, 15);
          end else begin
            run_stall = 1'b1;
            run_left = $urandom_range(30, 80);
          end
        end
        run_left--;
        out_stall <= run_stall;
      end
    end
  end

  function automatic int idle_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    tracker.decode_byte(b);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[i*8 +: 8]);
  endtask

  // fill below zero means random difference bytes
  task automatic run_block(input logic [15:0] ch, input logic [3:0] sz, input logic [11:0] n,
                           input logic [31:0] first, input int fill);
    send_word({ch, sz, n});
    if (tracker.stage == AT_FIRST) send_word(first);
    while (tracker.stage != AT_HEADER) send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
  endtask

  // random bytes, then whatever it takes to get back to a header boundary
  task automatic send_noise();
    repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
    while (!(tracker.stage == AT_HEADER && tracker.byte_pos == 2'd0)) send_byte(8'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_rate(input logic [11:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.max_rate = v;
  endtask

  task automatic random_phase(input int quota);
    int start;
    int r;
    int lim;
    int top;
    logic [31:0] first;
    start = tracker.bytes_in;
    top = int'(tracker.max_rate);
    while (tracker.bytes_in - start < quota) begin
      sender_calm = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 7) begin
        run_block(16'($urandom), 4'($urandom), 12'd0, '0, -1);
      end else if (r < 13 && top < 4095) begin
        run_block(16'($urandom), 4'($urandom), 12'($urandom_range(top + 1, 4095)), '0, -1);
      end else if (r < 19 && top >= 2) begin
        run_block(16'($urandom), 4'($urandom_range(5, 15)), 12'($urandom_range(2, top)),
                  '0, -1);
      end else if (r < 26 && top <= 40) begin
        send_noise();
      end else begin
        lim = (top < 24) ? top : 24;
        if ($urandom_range(0, 19) == 0) lim = (top < 64) ? top : 64;
        case ($urandom_range(0, 9))
          0: first = 32'h7fff_ffff;
          1: first = 32'h8000_0000;
          default: first = $urandom;
        endcase
        run_block(16'($urandom), 4'($urandom_range(0, 4)),
                  ($urandom_range(0, 9) == 0) ? 12'(lim) : 12'($urandom_range(1, lim)),
                  first, -1);
      end
    end
    sender_calm = 1'b0;
  endtask

  initial begin
    int waited;
    tracker = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed blocks at the reset rate limit
    run_block(16'h0000, 4'd0, 12'd1, 32'h0000_0000, -1);
    run_block(16'hffff, 4'hf, 12'd1, 32'h7fff_ffff, -1);
    run_block(16'h1234, 4'd0, 12'd0, '0, -1);
    run_block(16'hffff, 4'hf, 12'd0, '0, -1);
    run_block(16'h0001, 4'd1, 12'd1001, '0, -1);
    run_block(16'h8000, 4'hf, 12'hfff, '0, -1);
    run_block(16'h00aa, 4'd5, 12'd10, '0, -1);
    run_block(16'h5555, 4'hf, 12'd1000, '0, -1);
    run_block(16'h0002, 4'd0, 12'd2, 32'h0000_0010, 8'h87);
    run_block(16'h0003, 4'd0, 12'd5, 32'h7fff_fffc, 8'h77);
    run_block(16'h0004, 4'd0, 12'd6, 32'h8000_0003, 8'h88);
    run_block(16'h0005, 4'd1, 12'd4, 32'h8000_0000, 8'h80);
    run_block(16'h0006, 4'd1, 12'd3, 32'h7fff_ff80, 8'h7f);
    run_block(16'h0007, 4'd2, 12'd3, 32'hffff_ffff, 8'h7f);
    run_block(16'h0008, 4'd3, 12'd3, 32'h0000_0001, -1);
    run_block(16'h0009, 4'd4, 12'd3, 32'h1234_5678, 8'hff);
    settle();

    set_max_rate(12'd1);
    random_phase(PHASE_BYTES);
    settle();

    // receiver holds off while the sender keeps offering items
    set_max_rate(12'd16);
    hold_left = 400;
    random_phase(PHASE_BYTES);
    settle();

    set_max_rate(12'hfff);
    random_phase(PHASE_BYTES);
    run_block(16'hfedc, 4'd0, 12'd64, 32'h7fff_fff0, -1);
    settle();

    set_max_rate(12'd40);
    random_phase(PHASE_BYTES);
    settle();

    mid_rate = $urandom_range(41, 600);
    set_max_rate(12'(mid_rate));
    random_phase(PHASE_BYTES);
    settle();

    set_max_rate(scbd_pkg::MAX_RATE_RESET);
    random_phase(PHASE_BYTES);
    in_valid <= 1'b0;

    waited = 0;
    while (tracker.due_outputs.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.due_outputs.size() != 0) begin
      $error("%0d expected results never arrived", tracker.due_outputs.size());
      tracker.failures += tracker.due_outputs.size();
    end

    $display("%0d stream bytes decoded; checked %0d headers, %0d samples, %0d error results",
             tracker.bytes_in, tracker.headers, tracker.samples, tracker.errors);
    $display("rate limit swept over 1, 16, 4095, 40, %0d and 1000, with a long output hold",
             mid_rate);
    if (tracker.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/scbd_pkg.sv
rtl/core/scbd_front.sv
rtl/core/scbd_queue.sv
rtl/core/scbd_back.sv
rtl/core/seismic_channel_block_decoder.sv
verif/testbench.sv
